FILE: rtl/pba_pkg.sv
package pba_pkg;

  localparam int unsigned PAGE_BYTES  = 4096;
  localparam int unsigned NUM_BUCKETS = 18;
  localparam int unsigned HEAP_BYTES  = 1048576;

  localparam int unsigned HDR_BYTES   = 4;
  localparam int unsigned SLOT_BYTES  = 8;
  localparam int unsigned STORE_DEPTH = HEAP_BYTES / SLOT_BYTES;
  localparam int unsigned IDX_W       = $clog2(STORE_DEPTH);
  localparam int unsigned LINK_W      = IDX_W + 1;
  localparam int unsigned PG_W        = $clog2(PAGE_BYTES);
  localparam int unsigned PAGE_BKT    = $clog2(PAGE_BYTES / SLOT_BYTES);
  localparam int unsigned CNT_W       = PAGE_BKT;
  localparam int unsigned BKT_W       = 5;
  localparam int unsigned HB_W        = $clog2(NUM_BUCKETS);
  localparam int unsigned TAG_W       = 6;

  localparam logic [31:0] HS_RESET = 32'h003E_0000;
  localparam logic [31:0] HE_RESET = 32'h004E_0000;

  localparam logic CFG_HEAP_START = 1'b0;
  localparam logic CFG_HEAP_END   = 1'b1;

  typedef enum logic [1:0] {
    REQ_ALLOC = 2'd0,
    REQ_FREE  = 2'd1,
    REQ_QUERY = 2'd2
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_NOMEM  = 2'd1,
    ST_TOOBIG = 2'd2,
    ST_BADBLK = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ALIGN, S_HEAD, S_REFILL, S_CARVE,
    S_POP_RD, S_POP_WR, S_FIND_RD, S_FIND_CHK, S_DONE
  } state_t;

  typedef enum logic [3:0] {
    CMD_NONE, CMD_CLEAR, CMD_LOAD, CMD_ALIGN, CMD_HEAD, CMD_REFILL, CMD_CARVE,
    CMD_POP_RD, CMD_POP_WR, CMD_FIND_RD, CMD_FIND_CHK, CMD_EMIT
  } cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic       aligned;
    logic       align_ok;
    logic       bkt_ok;
    logic       head_empty;
    logic       grow_ok;
    logic       carve_last;
    logic       pop_bad;
    logic [1:0] in_req;
    logic       in_addr_null;
  } dp_status_t;

endpackage

FILE: rtl/pba_req_if.sv
interface pba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  req_type;
  logic [31:0] size_bytes;
  logic [31:0] block_address;

  modport source (output valid, output req_type, output size_bytes,
                  output block_address, input ready);
  modport sink (input valid, input req_type, input size_bytes,
                input block_address, output ready);
endinterface

FILE: rtl/pba_rsp_if.sv
interface pba_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] result_address;
  logic [4:0]  bucket_index;

  modport source (output valid, output status, output result_address,
                  output bucket_index, input ready);
  modport sink (input valid, input status, input result_address,
                input bucket_index, output ready);
endinterface

FILE: rtl/pba_datapath.sv
module pba_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  pba_pkg::cmd_t       cmd,
  input  logic [1:0]          in_req_type,
  input  logic [31:0]         in_size_bytes,
  input  logic [31:0]         in_block_address,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [31:0]         cfg_wdata,
  output logic [1:0]          out_status,
  output logic [31:0]         out_result_address,
  output logic [4:0]          out_bucket_index,
  output pba_pkg::dp_status_t st
);

  // configuration and heap state
  logic [31:0] hs_r, he_r, bp_r;
  logic        aligned_r;
  logic [pba_pkg::LINK_W-1:0] heads_r [pba_pkg::NUM_BUCKETS];
  logic [pba_pkg::IDX_W-1:0]  clr_cnt_r;

  // per-request working registers
  logic [1:0]  req_r;
  logic [31:0] size_r, addr_r;
  logic [pba_pkg::BKT_W-1:0] bkt_r;
  logic        bkt_ok_r;
  logic [pba_pkg::IDX_W-1:0] idx_r;
  logic [pba_pkg::CNT_W-1:0] cnt_r;
  logic        find_pre_r;
  logic [1:0]  res_status_r;
  logic [31:0] res_addr_r;
  logic [pba_pkg::BKT_W-1:0] res_bkt_r;
  logic [1:0]  out_status_r;
  logic [31:0] out_addr_r;
  logic [pba_pkg::BKT_W-1:0] out_bkt_r;

  // memories
  logic [pba_pkg::LINK_W-1:0] link_mem [pba_pkg::STORE_DEPTH];
  logic [pba_pkg::TAG_W-1:0]  tag_mem  [pba_pkg::STORE_DEPTH];
  logic [pba_pkg::LINK_W-1:0] link_rd_r;
  logic [pba_pkg::TAG_W-1:0]  tag_rd_r;

  // break limit
  logic [32:0] hs_plus, lim;
  logic        bp_ge_hs;
  assign hs_plus  = {1'b0, hs_r} + 33'(pba_pkg::HEAP_BYTES);
  assign lim      = ({1'b0, he_r} < hs_plus) ? {1'b0, he_r} : hs_plus;
  assign bp_ge_hs = bp_r >= hs_r;

  // first-allocate alignment pad
  logic [pba_pkg::PG_W-1:0] pad;
  logic [32:0] bp_pad;
  logic        align_ok;
  assign pad      = pba_pkg::PG_W'(pba_pkg::PAGE_BYTES - pba_pkg::HDR_BYTES) -
                    bp_r[pba_pkg::PG_W-1:0];
  assign bp_pad   = {1'b0, bp_r} + 33'(pad);
  assign align_ok = (pad == '0) || (bp_ge_hs && (bp_pad < lim));

  // size to bucket: lowest class whose capacity covers the size
  logic [pba_pkg::NUM_BUCKETS-1:0] fits;
  logic [pba_pkg::BKT_W-1:0]       bkt_sel;
  logic                            bkt_hit;
  always_comb begin
    logic [33:0] cap;
    fits    = '0;
    bkt_sel = '0;
    bkt_hit = 1'b0;
    for (int b = 0; b < pba_pkg::NUM_BUCKETS; b++) begin
      if (b < pba_pkg::PAGE_BKT) begin
        cap = (34'(pba_pkg::SLOT_BYTES) << b) - 34'(pba_pkg::HDR_BYTES);
      end else begin
        cap = (34'(pba_pkg::SLOT_BYTES) << b) +
              34'(pba_pkg::PAGE_BYTES - pba_pkg::HDR_BYTES);
      end
      fits[b] = {2'b00, size_r} <= cap;
    end
    for (int b = pba_pkg::NUM_BUCKETS - 1; b >= 0; b--) begin
      if (fits[b]) begin
        bkt_sel = pba_pkg::BKT_W'(b);
        bkt_hit = 1'b1;
      end
    end
  end

  // refill: grow the break by a page or by block plus page
  logic [33:0] sz, amt;
  logic        grow_ok;
  logic [31:0] off_bp;
  logic [pba_pkg::IDX_W-1:0] idx0;
  assign sz      = 34'(pba_pkg::SLOT_BYTES) << bkt_r;
  assign amt     = (sz < 34'(pba_pkg::PAGE_BYTES)) ? 34'(pba_pkg::PAGE_BYTES)
                                                   : sz + 34'(pba_pkg::PAGE_BYTES);
  assign grow_ok = (amt <= 34'h0_FFFF_FFFF) && bp_ge_hs &&
                   (({2'b00, bp_r} + amt) < {1'b0, lim});
  assign off_bp  = bp_r - hs_r;
  assign idx0    = off_bp[pba_pkg::IDX_W+2:3];

  // carve: link each block to the next, last one null
  logic [pba_pkg::LINK_W-1:0] stride, link_next, carve_link;
  logic [pba_pkg::CNT_W:0]    nblk;
  logic [pba_pkg::CNT_W-1:0]  last_cnt;
  logic                       carve_last;
  assign stride     = pba_pkg::LINK_W'(1) << bkt_r;
  assign link_next  = {1'b0, idx_r} + stride + pba_pkg::LINK_W'(1);
  assign nblk       = (pba_pkg::CNT_W+1)'(pba_pkg::PAGE_BYTES / pba_pkg::SLOT_BYTES) >> bkt_r;
  assign last_cnt   = (bkt_r < pba_pkg::BKT_W'(pba_pkg::PAGE_BKT)) ?
                      nblk[pba_pkg::CNT_W-1:0] - pba_pkg::CNT_W'(1) : '0;
  assign carve_last = cnt_r == last_cnt;
  assign carve_link = carve_last ? '0 : link_next;

  // pop the bucket head
  logic [pba_pkg::LINK_W-1:0] head;
  logic                       pop_bad;
  logic [pba_pkg::IDX_W-1:0]  pop_idx;
  logic [31:0] base, blk_op, alloc_addr;
  assign head       = heads_r[bkt_r[pba_pkg::HB_W-1:0]];
  assign pop_bad    = (head == '0) || (head > pba_pkg::LINK_W'(pba_pkg::STORE_DEPTH));
  assign pop_idx    = pba_pkg::IDX_W'(head - pba_pkg::LINK_W'(1));
  assign base       = hs_r + 32'({idx_r, 3'b000});
  assign blk_op     = base + {29'd0, 3'd4 - base[2:0]};
  assign alloc_addr = blk_op + 32'(pba_pkg::HDR_BYTES);

  // locate a block from its payload address
  logic [31:0] fop, foff;
  logic        find_pre, find_ok;
  logic [pba_pkg::IDX_W-1:0] find_idx;
  logic [pba_pkg::BKT_W-1:0] fb;
  assign fop      = addr_r - 32'(pba_pkg::HDR_BYTES);
  assign foff     = fop - hs_r;
  assign find_pre = (addr_r >= 32'(pba_pkg::HDR_BYTES)) && (fop[2:0] == 3'd4) &&
                    (fop >= hs_r) && (fop < bp_r) &&
                    (foff[31:pba_pkg::IDX_W+3] == '0);
  assign find_idx = foff[pba_pkg::IDX_W+2:3];
  assign fb       = tag_rd_r[pba_pkg::BKT_W-1:0];
  assign find_ok  = find_pre_r && tag_rd_r[pba_pkg::TAG_W-1] &&
                    (fb < pba_pkg::BKT_W'(pba_pkg::NUM_BUCKETS));

  // memory port selection
  logic link_we, tag_we;
  logic [pba_pkg::IDX_W-1:0]  link_wa, tag_wa, tag_ra;
  logic [pba_pkg::LINK_W-1:0] link_wd;
  logic [pba_pkg::TAG_W-1:0]  tag_wd;
  always_comb begin
    link_we = 1'b0;
    link_wa = idx_r;
    link_wd = carve_link;
    tag_we  = 1'b0;
    tag_wa  = idx_r;
    tag_wd  = '0;
    tag_ra  = find_idx;
    case (cmd)
      pba_pkg::CMD_CLEAR: begin
        tag_we = 1'b1;
        tag_wa = clr_cnt_r;
      end
      pba_pkg::CMD_CARVE: begin
        link_we = 1'b1;
      end
      pba_pkg::CMD_POP_WR: begin
        tag_we = 1'b1;
        tag_wd = {1'b1, bkt_r};
      end
      pba_pkg::CMD_FIND_CHK: begin
        if (find_ok && req_r == pba_pkg::REQ_FREE) begin
          tag_we  = 1'b1;
          link_we = 1'b1;
          link_wd = heads_r[fb[pba_pkg::HB_W-1:0]];
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (link_we) link_mem[link_wa] <= link_wd;
    if (cmd == pba_pkg::CMD_POP_RD) link_rd_r <= link_mem[pop_idx];
  end

  always_ff @(posedge clk) begin
    if (tag_we) tag_mem[tag_wa] <= tag_wd;
    if (cmd == pba_pkg::CMD_FIND_RD) tag_rd_r <= tag_mem[tag_ra];
  end

  // heap control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hs_r      <= pba_pkg::HS_RESET;
      he_r      <= pba_pkg::HE_RESET;
      bp_r      <= pba_pkg::HS_RESET;
      aligned_r <= 1'b0;
      clr_cnt_r <= '0;
      for (int b = 0; b < pba_pkg::NUM_BUCKETS; b++) heads_r[b] <= '0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == pba_pkg::CFG_HEAP_START) begin
          hs_r <= cfg_wdata;
          if (!aligned_r) bp_r <= cfg_wdata;
        end else begin
          he_r <= cfg_wdata;
        end
      end
      case (cmd)
        pba_pkg::CMD_CLEAR: clr_cnt_r <= clr_cnt_r + pba_pkg::IDX_W'(1);
        pba_pkg::CMD_ALIGN: begin
          if (!aligned_r && align_ok) begin
            aligned_r <= 1'b1;
            bp_r      <= bp_pad[31:0];
          end
        end
        pba_pkg::CMD_REFILL: begin
          if (grow_ok) begin
            bp_r <= 32'({2'b00, bp_r} + amt);
            heads_r[bkt_r[pba_pkg::HB_W-1:0]] <= {1'b0, idx0} + pba_pkg::LINK_W'(1);
          end
        end
        pba_pkg::CMD_POP_WR: heads_r[bkt_r[pba_pkg::HB_W-1:0]] <= link_rd_r;
        pba_pkg::CMD_FIND_CHK: begin
          if (find_ok && req_r == pba_pkg::REQ_FREE) begin
            heads_r[fb[pba_pkg::HB_W-1:0]] <= {1'b0, idx_r} + pba_pkg::LINK_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // request payload and result registers
  always_ff @(posedge clk) begin
    case (cmd)
      pba_pkg::CMD_LOAD: begin
        req_r      <= in_req_type;
        size_r     <= in_size_bytes;
        addr_r     <= in_block_address;
        res_addr_r <= '0;
        res_bkt_r  <= '0;
        if ((in_req_type == pba_pkg::REQ_QUERY && in_block_address == '0) ||
            (in_req_type != pba_pkg::REQ_ALLOC && in_req_type != pba_pkg::REQ_FREE &&
             in_req_type != pba_pkg::REQ_QUERY)) begin
          res_status_r <= pba_pkg::ST_BADBLK;
        end else begin
          res_status_r <= pba_pkg::ST_OK;
        end
      end
      pba_pkg::CMD_ALIGN: begin
        bkt_r    <= bkt_sel;
        bkt_ok_r <= bkt_hit;
        if (!aligned_r && !align_ok) res_status_r <= pba_pkg::ST_NOMEM;
      end
      pba_pkg::CMD_HEAD: begin
        if (!bkt_ok_r) res_status_r <= pba_pkg::ST_TOOBIG;
      end
      pba_pkg::CMD_REFILL: begin
        idx_r <= idx0;
        cnt_r <= '0;
        if (!grow_ok) res_status_r <= pba_pkg::ST_NOMEM;
      end
      pba_pkg::CMD_CARVE: begin
        idx_r <= idx_r + stride[pba_pkg::IDX_W-1:0];
        cnt_r <= cnt_r + pba_pkg::CNT_W'(1);
      end
      pba_pkg::CMD_POP_RD: begin
        idx_r <= pop_idx;
        if (pop_bad) res_status_r <= pba_pkg::ST_NOMEM;
      end
      pba_pkg::CMD_POP_WR: begin
        res_addr_r <= alloc_addr;
        res_bkt_r  <= bkt_r;
      end
      pba_pkg::CMD_FIND_RD: begin
        find_pre_r <= find_pre;
        idx_r      <= find_idx;
      end
      pba_pkg::CMD_FIND_CHK: begin
        if (!find_ok) begin
          res_status_r <= pba_pkg::ST_BADBLK;
        end else if (req_r == pba_pkg::REQ_QUERY) begin
          res_bkt_r <= fb;
        end
      end
      pba_pkg::CMD_EMIT: begin
        out_status_r <= res_status_r;
        out_addr_r   <= res_addr_r;
        out_bkt_r    <= res_bkt_r;
      end
      default: begin
      end
    endcase
  end

  assign out_status         = out_status_r;
  assign out_result_address = out_addr_r;
  assign out_bucket_index   = out_bkt_r;

  assign st.clr_done     = clr_cnt_r == pba_pkg::IDX_W'(pba_pkg::STORE_DEPTH - 1);
  assign st.aligned      = aligned_r;
  assign st.align_ok     = align_ok;
  assign st.bkt_ok       = bkt_ok_r;
  assign st.head_empty   = head == '0;
  assign st.grow_ok      = grow_ok;
  assign st.carve_last   = carve_last;
  assign st.pop_bad      = pop_bad;
  assign st.in_req       = in_req_type;
  assign st.in_addr_null = in_block_address == '0;

endmodule

FILE: rtl/pba_controller.sv
module pba_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                out_ready,
  input  pba_pkg::dp_status_t st,
  output pba_pkg::cmd_t       cmd,
  output logic                in_ready,
  output logic                out_valid
);

  pba_pkg::state_t state_r, state_nxt;
  logic            out_valid_r, out_valid_nxt;

  // state and output-valid registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pba_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // sequence each request through the datapath
  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = pba_pkg::CMD_NONE;
    in_ready      = 1'b0;
    case (state_r)
      pba_pkg::S_CLEAR: begin
        cmd = pba_pkg::CMD_CLEAR;
        if (st.clr_done) state_nxt = pba_pkg::S_IDLE;
      end
      pba_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd = pba_pkg::CMD_LOAD;
          case (st.in_req)
            pba_pkg::REQ_ALLOC: state_nxt = pba_pkg::S_ALIGN;
            pba_pkg::REQ_FREE,
            pba_pkg::REQ_QUERY: state_nxt = st.in_addr_null ? pba_pkg::S_DONE
                                                            : pba_pkg::S_FIND_RD;
            default:            state_nxt = pba_pkg::S_DONE;
          endcase
        end
      end
      pba_pkg::S_ALIGN: begin
        cmd       = pba_pkg::CMD_ALIGN;
        state_nxt = (!st.aligned && !st.align_ok) ? pba_pkg::S_DONE : pba_pkg::S_HEAD;
      end
      pba_pkg::S_HEAD: begin
        cmd = pba_pkg::CMD_HEAD;
        if (!st.bkt_ok)         state_nxt = pba_pkg::S_DONE;
        else if (st.head_empty) state_nxt = pba_pkg::S_REFILL;
        else                    state_nxt = pba_pkg::S_POP_RD;
      end
      pba_pkg::S_REFILL: begin
        cmd       = pba_pkg::CMD_REFILL;
        state_nxt = st.grow_ok ? pba_pkg::S_CARVE : pba_pkg::S_DONE;
      end
      pba_pkg::S_CARVE: begin
        cmd = pba_pkg::CMD_CARVE;
        if (st.carve_last) state_nxt = pba_pkg::S_POP_RD;
      end
      pba_pkg::S_POP_RD: begin
        cmd       = pba_pkg::CMD_POP_RD;
        state_nxt = st.pop_bad ? pba_pkg::S_DONE : pba_pkg::S_POP_WR;
      end
      pba_pkg::S_POP_WR: begin
        cmd       = pba_pkg::CMD_POP_WR;
        state_nxt = pba_pkg::S_DONE;
      end
      pba_pkg::S_FIND_RD: begin
        cmd       = pba_pkg::CMD_FIND_RD;
        state_nxt = pba_pkg::S_FIND_CHK;
      end
      pba_pkg::S_FIND_CHK: begin
        cmd       = pba_pkg::CMD_FIND_CHK;
        state_nxt = pba_pkg::S_DONE;
      end
      pba_pkg::S_DONE: begin
        // hand the result over once the output register is free
        if (!out_valid_r || out_ready) begin
          cmd           = pba_pkg::CMD_EMIT;
          out_valid_nxt = 1'b1;
          state_nxt     = pba_pkg::S_IDLE;
        end
      end
      default: state_nxt = pba_pkg::S_IDLE;
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

FILE: rtl/power_of_two_bucket_allocator.sv
// Allocate: align the break on the first allocate, pick the bucket and check its head,
//   refill an empty bucket list, then pop the head; on a refill the carve loop writes
//   one link per cycle through the link memory port. Free/query: read the block tag,
//   then check it, a null address skipping both; a stalled result waits in the done state.
// Throughput: one request at a time; the next is taken once the result is registered.
// Reset: synchronous active-low; then a clearing pass over all 131072 entries of the tag
//   memory runs before the first request is taken (configuration writes are taken).
module power_of_two_bucket_allocator (
  input  logic        clk,
  input  logic        rst_n,
  pba_req_if.sink     in_ch,
  pba_rsp_if.source   out_ch,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [31:0] cfg_wdata
);

  pba_pkg::cmd_t       cmd;
  pba_pkg::dp_status_t st;

  pba_controller u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .out_ready (out_ch.ready),
    .st        (st),
    .cmd       (cmd),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid)
  );

  pba_datapath u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .cmd                (cmd),
    .in_req_type        (in_ch.req_type),
    .in_size_bytes      (in_ch.size_bytes),
    .in_block_address   (in_ch.block_address),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata),
    .out_status         (out_ch.status),
    .out_result_address (out_ch.result_address),
    .out_bucket_index   (out_ch.bucket_index),
    .st                 (st)
  );

endmodule

FILE: tb/tb_power_of_two_bucket_allocator.sv
`timescale 1ns / 1ps

module tb_power_of_two_bucket_allocator;
  import pba_pkg::*;

  localparam int          RUN_LIMIT = 4000000;
  localparam logic [5:0]  TAG_BUSY  = 6'h20;
  localparam logic [5:0]  TAG_BKT   = 6'h1f;

  typedef struct {
    logic [1:0]  kind;
    logic [31:0] size;
    logic [31:0] addr;
  } request_t;

  typedef struct {
    status_t     st;
    logic [31:0] addr;
    logic [4:0]  bkt;
  } outcome_t;

  logic clk;
  logic rst_n;
  logic        cfg_we;
  logic        cfg_index;
  logic [31:0] cfg_wdata;

  pba_req_if req_ch ();
  pba_rsp_if rsp_ch ();

  power_of_two_bucket_allocator u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (req_ch),
    .out_ch   (rsp_ch),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Allocator state mirror
  logic [31:0]       heap_lo;
  logic [31:0]       heap_hi;
  logic [31:0]       brk;
  bit                page_aligned;
  logic [LINK_W-1:0] list_head [NUM_BUCKETS];
  logic [LINK_W-1:0] link_mem  [STORE_DEPTH];
  logic [5:0]        tag_mem   [STORE_DEPTH];
  logic [31:0]       live_blocks [$];

  request_t request_queue [$];
  outcome_t result_queue  [$];

  int  fails;
  int  mismatches;
  int  cycles;
  int  gap_left;
  int  stall_left;
  bit  req_taken;
  bit  no_idle;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic bit heap_grow(longint unsigned amt, output logic [31:0] old);
    longint unsigned lim;
    lim = longint'(heap_lo) + HEAP_BYTES;
    if (longint'(heap_hi) < lim) lim = heap_hi;
    old = brk;
    if (brk < heap_lo) return 0;
    if (longint'(brk) + amt >= lim) return 0;
    brk = brk + amt[31:0];
    return 1;
  endfunction

  function automatic bit bucket_of_size(logic [31:0] size, output logic [4:0] bkt);
    longint unsigned s, amt, extra;
    int b;
    s = size;
    bkt = '0;
    if (s <= PAGE_BYTES - HDR_BYTES) begin
      amt = SLOT_BYTES;
      b = 0;
      extra = 0;
      s = s + HDR_BYTES;
    end else begin
      amt = PAGE_BYTES;
      b = PAGE_BKT;
      extra = PAGE_BYTES - HDR_BYTES;
    end
    if (b >= NUM_BUCKETS) return 0;
    while (s > amt + extra) begin
      amt = amt << 1;
      b++;
      if (b >= NUM_BUCKETS) return 0;
    end
    bkt = b[4:0];
    return 1;
  endfunction

  // Bump the break and thread the new blocks onto the bucket list
  function automatic void carve_bucket(int b);
    longint unsigned sz, amt, n, idx, nxt;
    logic [31:0] op;
    sz = longint'(SLOT_BYTES) << b;
    if (sz < PAGE_BYTES) begin
      amt = PAGE_BYTES;
      n = PAGE_BYTES / sz;
    end else begin
      amt = sz + PAGE_BYTES;
      n = 1;
    end
    if (amt > 64'hffff_ffff) return;
    if (!heap_grow(amt, op)) return;
    for (longint unsigned k = 0; k < n; k++) begin
      idx = (longint'(op) + k * sz - longint'(heap_lo)) >> 3;
      nxt = (longint'(op) + (k + 1) * sz - longint'(heap_lo)) >> 3;
      if (idx >= STORE_DEPTH) break;
      if (k == 0) list_head[b] = LINK_W'(idx + 1);
      link_mem[idx] = (k + 1 < n) ? LINK_W'(nxt + 1) : '0;
    end
  endfunction

  // Slot number plus one of the in-use block at this payload address, else 0
  function automatic int unsigned locate_block(logic [31:0] addr);
    logic [31:0] op, idx;
    if (addr < HDR_BYTES) return 0;
    op = addr - HDR_BYTES;
    if (op[2:0] != 3'd4 || op < heap_lo || op >= brk) return 0;
    idx = (op - heap_lo) >> 3;
    if (idx >= STORE_DEPTH) return 0;
    if ((tag_mem[idx] & TAG_BUSY) == 0) return 0;
    if ((tag_mem[idx] & TAG_BKT) >= NUM_BUCKETS) return 0;
    return idx + 1;
  endfunction

  function automatic outcome_t apply_request(logic [1:0] kind, logic [31:0] size,
                                             logic [31:0] addr);
    outcome_t res;
    logic [31:0] r, pad, old, base, op;
    logic [4:0]  b;
    int unsigned h, idx;
    bit ok;
    res.st = ST_OK;
    res.addr = '0;
    res.bkt = '0;
    case (kind)
      REQ_ALLOC: begin
        ok = 1;
        if (!page_aligned) begin
          r = brk & (PAGE_BYTES - 1);
          pad = (PAGE_BYTES - HDR_BYTES - r) & (PAGE_BYTES - 1);
          if (pad != 0 && !heap_grow(pad, old)) ok = 0;
          else page_aligned = 1;
        end
        if (!ok) begin
          res.st = ST_NOMEM;
        end else if (!bucket_of_size(size, b)) begin
          res.st = ST_TOOBIG;
        end else begin
          if (list_head[b] == 0) carve_bucket(b);
          h = list_head[b];
          if (h == 0 || h > STORE_DEPTH) begin
            res.st = ST_NOMEM;
          end else begin
            idx = h - 1;
            base = heap_lo + (idx << 3);
            op = base + ((32'd4 - base) & 32'd7);
            list_head[b] = link_mem[idx];
            tag_mem[idx] = TAG_BUSY | {1'b0, b};
            res.addr = op + HDR_BYTES;
            res.bkt = b;
            live_blocks.push_back(res.addr);
          end
        end
      end
      REQ_FREE: begin
        if (addr != 0) begin
          h = locate_block(addr);
          if (h == 0) begin
            res.st = ST_BADBLK;
          end else begin
            idx = h - 1;
            b = tag_mem[idx][4:0];
            tag_mem[idx] = '0;
            link_mem[idx] = list_head[b];
            list_head[b] = LINK_W'(h);
            foreach (live_blocks[i]) begin
              if (live_blocks[i] == addr) begin
                live_blocks.delete(i);
                break;
              end
            end
          end
        end
      end
      REQ_QUERY: begin
        h = (addr != 0) ? locate_block(addr) : 0;
        if (h == 0) res.st = ST_BADBLK;
        else res.bkt = tag_mem[h - 1][4:0];
      end
      default: res.st = ST_BADBLK;
    endcase
    return res;
  endfunction

  // Sample transfers on the rising edge: predict inputs, check results
  always @(posedge clk) begin
    outcome_t want;
    cycles <= cycles + 1;
    req_taken = rst_n && req_ch.valid && req_ch.ready;
    if (req_taken)
      result_queue.push_back(apply_request(req_ch.req_type, req_ch.size_bytes,
                                           req_ch.block_address));
    if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
      if (result_queue.size() == 0) begin
        fails++;
        if (mismatches < 10)
          $display("unexpected result: status %0d addr %h bucket %0d",
                   rsp_ch.status, rsp_ch.result_address, rsp_ch.bucket_index);
        mismatches++;
      end else begin
        want = result_queue.pop_front();
        if (rsp_ch.status !== want.st || rsp_ch.result_address !== want.addr ||
            rsp_ch.bucket_index !== want.bkt) begin
          fails++;
          if (mismatches < 10)
            $display("mismatch: expected status %0d addr %h bucket %0d, got %0d %h %0d",
                     want.st, want.addr, want.bkt, rsp_ch.status,
                     rsp_ch.result_address, rsp_ch.bucket_index);
          mismatches++;
        end
      end
    end
    if (cycles > RUN_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Feed requests on the falling edge with random gap bursts
  always @(negedge clk) begin
    request_t it;
    if (!rst_n) begin
      req_ch.valid <= 1'b0;
    end else if (!req_ch.valid || req_taken) begin
      if (gap_left > 0 && !no_idle) begin
        gap_left--;
        req_ch.valid <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 11) == 0) begin
        gap_left = $urandom_range(0, 16);
        req_ch.valid <= 1'b0;
      end else if (request_queue.size() > 0) begin
        it = request_queue.pop_front();
        req_ch.req_type <= it.kind;
        req_ch.size_bytes <= it.size;
        req_ch.block_address <= it.addr;
        req_ch.valid <= 1'b1;
      end else begin
        req_ch.valid <= 1'b0;
      end
    end
  end

  // Throttle the result side in random stall bursts
  always @(negedge clk) begin
    if (no_idle) begin
      rsp_ch.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      rsp_ch.ready <= 1'b0;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 16);
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= 1'b1;
    end
  end

  task automatic push_request(logic [1:0] kind, logic [31:0] size, logic [31:0] addr);
    request_t it;
    it.kind = kind;
    it.size = size;
    it.addr = addr;
    while (request_queue.size() > 2) @(posedge clk);
    request_queue.push_back(it);
  endtask

  // Hold until every request is answered and the block is quiet
  task automatic drain();
    while (request_queue.size() > 0 || req_ch.valid || result_queue.size() > 0)
      @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] data);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_HEAP_START) begin
      heap_lo = data;
      if (!page_aligned) brk = data;
    end else begin
      heap_hi = data;
    end
  endtask

  function automatic logic [31:0] random_size();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 60) return $urandom_range(0, 128);
    if (pick < 80) return $urandom_range(0, 4092);
    if (pick < 92) return $urandom_range(4093, 70000);
    if (pick < 95) return $urandom_range(70001, 600000);
    return $urandom;
  endfunction

  function automatic logic [31:0] random_block();
    int unsigned pick;
    logic [31:0] a;
    pick = $urandom_range(0, 99);
    if (live_blocks.size() == 0 || pick >= 90) return $urandom;
    a = live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    if (pick >= 85) a = a + $urandom_range(1, 7);
    return a;
  endfunction

  // Mostly alloc/free traffic over live blocks, with some noise
  task automatic random_traffic(int count);
    int unsigned pick;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 50) push_request(REQ_ALLOC, random_size(), '0);
      else if (pick < 80) push_request(REQ_FREE, $urandom, random_block());
      else if (pick < 95) push_request(REQ_QUERY, $urandom, random_block());
      else push_request(2'd3, $urandom, $urandom);
    end
  endtask

  initial begin
    logic [31:0] a;
    heap_lo = HS_RESET;
    heap_hi = HE_RESET;
    brk = HS_RESET;
    page_aligned = 0;
    foreach (list_head[i]) list_head[i] = '0;
    foreach (tag_mem[i]) tag_mem[i] = '0;
    foreach (link_mem[i]) link_mem[i] = '0;
    fails = 0;
    mismatches = 0;
    cycles = 0;
    gap_left = 0;
    stall_left = 0;
    req_taken = 0;
    no_idle = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_HEAP_START;
    cfg_wdata = '0;
    req_ch.valid = 1'b0;
    req_ch.req_type = REQ_ALLOC;
    req_ch.size_bytes = '0;
    req_ch.block_address = '0;
    rsp_ch.ready = 1'b0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Move the break before alignment; a tight end makes alignment fail twice
    write_reg(CFG_HEAP_START, 32'h0050_0000);
    write_reg(CFG_HEAP_START, 32'h0040_0123);
    write_reg(CFG_HEAP_END, 32'h0040_0200);
    push_request(REQ_ALLOC, 32'd16, '0);
    push_request(REQ_ALLOC, 32'd16, '0);
    drain();
    write_reg(CFG_HEAP_END, 32'hffff_ffff);

    // Directed corners
    push_request(REQ_ALLOC, 32'd0, '0);
    push_request(REQ_ALLOC, 32'd4092, '0);
    push_request(REQ_ALLOC, 32'd4093, '0);
    push_request(REQ_ALLOC, 32'hffff_ffff, '0);
    push_request(REQ_ALLOC, 32'd600000, '0);
    push_request(REQ_FREE, 32'hffff_ffff, '0);
    push_request(REQ_FREE, '0, 32'hffff_ffff);
    push_request(REQ_QUERY, '0, '0);
    push_request(REQ_QUERY, '0, 32'd1);
    push_request(2'd3, 32'hffff_ffff, 32'hffff_ffff);
    push_request(REQ_ALLOC, 32'd12, '0);
    drain();
    a = live_blocks[$];
    push_request(REQ_QUERY, '0, a);
    push_request(REQ_FREE, '0, a + 1);
    push_request(REQ_FREE, '0, a);
    push_request(REQ_FREE, '0, a);
    push_request(REQ_QUERY, '0, a);
    push_request(REQ_ALLOC, 32'd12, '0);
    random_traffic(350);
    drain();

    // Heap pinned at zero with no room to grow
    write_reg(CFG_HEAP_START, 32'h0000_0000);
    write_reg(CFG_HEAP_END, 32'h0000_0000);
    random_traffic(120);
    drain();

    // Heap base above the break: only recycled blocks can be handed out
    write_reg(CFG_HEAP_START, 32'hffff_f000);
    write_reg(CFG_HEAP_END, 32'hffff_ffff);
    random_traffic(150);
    drain();

    // Back to the working heap; finish without idling
    write_reg(CFG_HEAP_START, 32'h0040_0123);
    write_reg(CFG_HEAP_END, 32'hffff_ffff);
    random_traffic(230);
    no_idle = 1;
    random_traffic(150);
    drain();
    repeat (600) @(posedge clk);
    if (result_queue.size() > 0) fails++;

    if (fails == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

FILE: power_of_two_bucket_allocator.f
rtl/pba_pkg.sv
rtl/pba_req_if.sv
rtl/pba_rsp_if.sv
rtl/pba_datapath.sv
rtl/pba_controller.sv
rtl/power_of_two_bucket_allocator.sv
tb/tb_power_of_two_bucket_allocator.sv
